### design/sdbo_pkg.sv
// package: shared types and constants for the shared deferred binary output
`timescale 1ns / 1ps

package sdbo_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_EXT_W   = 32;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_DELAYED   = 2'd0,
        MODE_IMMEDIATE = 2'd1,
        MODE_TICK      = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ON_DELAY  = 2'd0,
        CFG_OFF_DELAY = 2'd1,
        CFG_POLARITY  = 2'd2
    } cfg_index_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

### design/shared_deferred_binary_output.sv
// top level: reference-counted binary output with on-delay and off-delay
//
// input beats carry a mode (delayed request, immediate request, tick) and a
// request bit; every input beat yields exactly one result beat with the
// stored level, applied and changed flags, the consumer count and whether a
// deferred set is armed. delays are counted in tick beats.
// the result of an accepted input beat is registered in the result register.
// throughput is one beat per cycle: state is updated as each input beat is
// accepted, and the result register refills in the same cycle it drains.
// s_ready drops only while a result waits and m_ready is low, so a stalled
// receiver holds the result and the state stays put.
// configuration writes (cfg_wen, cfg_index, cfg_wdata) take effect at once
// and are expected only while no beat is in flight.
// synchronous active-low reset clears the consumer count, the timer, the
// stored level, the configuration and the valid flag; no result is valid after reset.
`timescale 1ns / 1ps

module shared_deferred_binary_output
    import sdbo_pkg::*;
#(
    parameter int DELAY_WIDTH = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [MODE_W-1:0]      s_mode,
    input  logic                   s_request,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_level,
    output logic                   m_applied,
    output logic                   m_changed,
    output logic [COUNT_W-1:0]     m_consumer_total,
    output logic                   m_timer_armed
);

    // configuration
    logic [DELAY_WIDTH-1:0] on_delay_reg;
    logic [DELAY_WIDTH-1:0] off_delay_reg;
    logic                   polarity_reg;
    logic [CFG_EXT_W-1:0]   cfg_wdata_ext;

    // state
    logic [COUNT_W-1:0]     consumers_reg,  consumers_next;
    logic [DELAY_WIDTH-1:0] remaining_reg,  remaining_next;
    logic                   pending_reg,    pending_next;
    logic                   pend_value_reg, pend_value_next;
    logic                   level_reg,      level_next;

    // result register
    logic                   m_valid_reg;
    logic                   m_level_reg;
    logic                   m_applied_reg;
    logic                   m_changed_reg;
    logic [COUNT_W-1:0]     m_consumer_total_reg;
    logic                   m_timer_armed_reg;

    logic                   s_accept;
    logic                   applied_next;
    logic                   apply_value;
    logic [DELAY_WIDTH-1:0] delay_sel;
    logic [COUNT_W-1:0]     cons_rel;
    logic                   immediate;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign cfg_wdata_ext = CFG_EXT_W'(cfg_wdata);

    assign delay_sel = s_request ? on_delay_reg : off_delay_reg;
    assign cons_rel  = (!s_request && consumers_reg != '0) ?
                       COUNT_W'(consumers_reg - 1'b1) : consumers_reg;
    assign immediate = (mode_t'(s_mode) == MODE_IMMEDIATE);

    always_comb begin
        consumers_next  = consumers_reg;
        remaining_next  = remaining_reg;
        pending_next    = pending_reg;
        pend_value_next = pend_value_reg;
        applied_next    = 1'b0;
        apply_value     = 1'b0;

        case (mode_t'(s_mode))
            MODE_DELAYED, MODE_IMMEDIATE: begin
                consumers_next = cons_rel;
                if (cons_rel == '0 && delay_sel != '0 && !immediate) begin
                    pend_value_next = s_request;
                    remaining_next  = delay_sel;
                    pending_next    = 1'b1;
                end else if ((cons_rel == '0 && (delay_sel == '0 || immediate)) ||
                             (s_request && cons_rel != '0 && immediate && pending_reg)) begin
                    pending_next   = 1'b0;
                    remaining_next = '0;
                    applied_next   = 1'b1;
                    apply_value    = s_request;
                end
                if (s_request && cons_rel != COUNT_MAX) begin
                    consumers_next = COUNT_W'(cons_rel + 1'b1);
                end
            end
            MODE_TICK: begin
                if (pending_reg) begin
                    if (remaining_reg <= DELAY_WIDTH'(1)) begin
                        remaining_next = '0;
                        pending_next   = 1'b0;
                        applied_next   = 1'b1;
                        apply_value    = pend_value_reg;
                    end else begin
                        remaining_next = DELAY_WIDTH'(remaining_reg - 1'b1);
                    end
                end
            end
            default: begin
                // unused mode leaves state as is
            end
        endcase

        level_next = applied_next ? (apply_value ? polarity_reg : !polarity_reg)
                                  : level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_delay_reg         <= '0;
            off_delay_reg        <= '0;
            polarity_reg         <= 1'b0;
            consumers_reg        <= '0;
            remaining_reg        <= '0;
            pending_reg          <= 1'b0;
            pend_value_reg       <= 1'b0;
            level_reg            <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_ON_DELAY:  on_delay_reg  <= cfg_wdata_ext[DELAY_WIDTH-1:0];
                    CFG_OFF_DELAY: off_delay_reg <= cfg_wdata_ext[DELAY_WIDTH-1:0];
                    CFG_POLARITY:  polarity_reg  <= cfg_wdata[0];
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
            if (s_accept) begin
                consumers_reg  <= consumers_next;
                remaining_reg  <= remaining_next;
                pending_reg    <= pending_next;
                pend_value_reg <= pend_value_next;
                level_reg      <= level_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_level_reg          <= level_next;
            m_applied_reg        <= applied_next;
            m_changed_reg        <= applied_next && (level_next != level_reg);
            m_consumer_total_reg <= consumers_next;
            m_timer_armed_reg    <= pending_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_level          = m_level_reg;
    assign m_applied        = m_applied_reg;
    assign m_changed        = m_changed_reg;
    assign m_consumer_total = m_consumer_total_reg;
    assign m_timer_armed    = m_timer_armed_reg;

    // an armed timer always has ticks left, an idle one is cleared
    a_timer_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == (remaining_reg != '0))
        else $error("timer count disagrees with pending flag");

    // a change is only reported for an applied set
    a_changed_needs_applied: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_changed_reg |-> m_applied_reg)
        else $error("changed flag without applied set");

    // applying a set always leaves no timer armed
    a_applied_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_applied_reg |-> !m_timer_armed_reg)
        else $error("timer still armed after applied set");

    // one beat moves the consumer count by at most one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ((COUNT_W+1)'(consumers_reg) + 1'b1 >= (COUNT_W+1)'($past(consumers_reg)))
                  && ((COUNT_W+1)'(consumers_reg) <= (COUNT_W+1)'($past(consumers_reg)) + 1'b1))
        else $error("consumer count jumped by more than one");

endmodule
